@@ rtl/tour_common_edge_ratio_core_assert.svh @@
// Assertion macros used by the checker of the tour common-edge ratio core.
`ifndef TOUR_COMMON_EDGE_RATIO_CORE_ASSERT_SVH
`define TOUR_COMMON_EDGE_RATIO_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TCER_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tcer check failed");

// Next-cycle implication, disabled while reset is high.
`define TCER_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tcer check failed");

`endif

@@ rtl/tcer_pkg.sv @@
// Shared constants and transfer types of the tour common-edge ratio core.
`default_nettype none

package tcer_pkg;

   // Node indices and the edge map geometry
   localparam int NODE_W    = 6;
   localparam int MAX_NODES = 2 ** NODE_W;
   localparam int ROWS      = 2 * MAX_NODES;
   localparam int ADDR_W    = NODE_W + 1;

   // Edge counts saturate at the largest tour length
   localparam int EDGE_W = 8;
   localparam logic [EDGE_W-1:0] MAX_TOUR_EDGES = 8'd255;

   // Ratio in Q1.16 and the accumulated tallies
   localparam int RATIO_W   = 17;
   localparam int FRAC_W    = 16;
   localparam int DIV_STEPS = FRAC_W + 1;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int TALLY_W   = 16;
   localparam int SUM_W     = 32;

   // Item codes
   localparam logic FUNC_NODE   = 1'b0;
   localparam logic FUNC_FORGET = 1'b1;

   typedef logic [MAX_NODES-1:0] row_type;

   typedef struct packed {
      logic              func;
      logic [NODE_W-1:0] node;
      logic              tour_end;
   } req_type;

   typedef struct packed {
      logic [RATIO_W-1:0] ratio_q16;
      logic [EDGE_W-1:0]  common_edges;
      logic [EDGE_W-1:0]  total_edges;
      logic               baseline_only;
      logic               identical;
      logic               length_mismatch;
      logic [TALLY_W-1:0] tours_compared;
      logic [TALLY_W-1:0] identical_tours;
      logic [SUM_W-1:0]   ratio_total;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/tcer_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tcer_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and read; a read of the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/tcer_div.sv @@
// Restoring divider producing the Q1.16 ratio of shared edges over total edges.
`default_nettype none

module tcer_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [tcer_pkg::EDGE_W-1:0]     numer,
   input  wire logic [tcer_pkg::EDGE_W-1:0]     denom,
   output logic                                 done,
   output logic      [tcer_pkg::RATIO_W-1:0]    quot
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [tcer_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [tcer_pkg::EDGE_W:0]       rem_ff, rem_in;
   logic [tcer_pkg::EDGE_W-1:0]     denom_ff, denom_in;
   logic [tcer_pkg::RATIO_W-1:0]    quot_ff, quot_in;
   logic [tcer_pkg::EDGE_W:0]       trial;
   logic                            fits;

   // One quotient bit per cycle; the first step takes the integer bit unshifted
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      quot_in  = quot_ff;
      trial    = (step_ff == '0) ? rem_ff : {rem_ff[tcer_pkg::EDGE_W-1:0], 1'b0};
      fits     = trial >= {1'b0, denom_ff};
      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         rem_in   = {1'b0, numer};
         denom_in = denom;
         quot_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? trial - {1'b0, denom_ff} : trial;
         quot_in = {quot_ff[tcer_pkg::RATIO_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == tcer_pkg::STEP_W'(tcer_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
      quot_ff  <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

@@ rtl/tour_common_edge_ratio_core.sv @@
// Steps: a forget transfer or the first node of a tour is taken in S_IDLE; each later node
// passes S_RD_P (baseline row read), then S_WR_P and S_WR_N (read-modify-write of both map
// rows on one read port). A tour end passes S_END, then S_DIV when a ratio is divided out
// (17 divider steps), then S_DONE; the result waits in one output register, and a second
// finished tour stalls input. Reset clears control; per-row valid flops mark the edge
// memory empty, so transfers are taken right after reset.
`default_nettype none

module tour_common_edge_ratio_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tcer_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tcer_pkg::rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_P,
      S_WR_P,
      S_WR_N,
      S_END,
      S_DIV,
      S_DONE
   } state_type;

   state_type                         state_ff, state_in;
   logic [1:0][tcer_pkg::MAX_NODES-1:0] live_ff, live_in;
   logic                              bank_sel_ff, bank_sel_in;
   logic                              have_base_ff, have_base_in;
   logic                              at_start_ff, at_start_in;
   logic [tcer_pkg::NODE_W-1:0]       prior_ff, prior_in;
   logic [tcer_pkg::NODE_W-1:0]       node_ff, node_in;
   logic                              last_ff, last_in;
   logic                              hit_ff, hit_in;
   tcer_pkg::row_type                 row_ff, row_in;
   logic [tcer_pkg::EDGE_W-1:0]       shared_ff, shared_in;
   logic [tcer_pkg::EDGE_W-1:0]       edges_ff, edges_in;
   logic [tcer_pkg::EDGE_W-1:0]       base_len_ff, base_len_in;
   logic [tcer_pkg::TALLY_W-1:0]      compared_ff, compared_in;
   logic [tcer_pkg::TALLY_W-1:0]      ident_cnt_ff, ident_cnt_in;
   logic [tcer_pkg::SUM_W-1:0]        ratio_acc_ff, ratio_acc_in;
   logic [tcer_pkg::RATIO_W-1:0]      ratio_ff, ratio_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   tcer_pkg::rsp_type                 rsp_data_ff, rsp_data_in;

   logic                              wbank;
   logic                              req_fire;
   logic                              wr_en;
   logic [tcer_pkg::ADDR_W-1:0]       wr_addr;
   tcer_pkg::row_type                 wr_data;
   logic [tcer_pkg::ADDR_W-1:0]       rd_addr;
   tcer_pkg::row_type                 rd_data;
   logic                              div_start;
   logic                              div_done;
   logic [tcer_pkg::RATIO_W-1:0]      div_quot;
   logic                              ident;
   logic                              mism;
   logic [tcer_pkg::SUM_W:0]          acc_sum;

   // Edge map: two halves, baseline tour and tour being written
   tcer_ram #(
      .WIDTH (tcer_pkg::MAX_NODES),
      .DEPTH (tcer_pkg::ROWS)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Serial divider for the ratio
   tcer_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (shared_ff),
      .denom (edges_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign wbank     = ~bank_sel_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Sequence each item through the edge map and finish each tour
   always_comb begin
      state_in     = state_ff;
      live_in      = live_ff;
      bank_sel_in  = bank_sel_ff;
      have_base_in = have_base_ff;
      at_start_in  = at_start_ff;
      prior_in     = prior_ff;
      node_in      = node_ff;
      last_in      = last_ff;
      hit_in       = hit_ff;
      row_in       = row_ff;
      shared_in    = shared_ff;
      edges_in     = edges_ff;
      base_len_in  = base_len_ff;
      compared_in  = compared_ff;
      ident_cnt_in = ident_cnt_ff;
      ratio_acc_in = ratio_acc_ff;
      ratio_in     = ratio_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = {wbank, prior_ff};
      wr_data      = row_ff;
      rd_addr      = {bank_sel_ff, prior_ff};
      div_start    = 1'b0;
      ident        = (edges_ff != '0) && (shared_ff == edges_ff);
      mism         = edges_ff != base_len_ff;
      acc_sum      = {1'b0, ratio_acc_ff}
                     + {{(tcer_pkg::SUM_W + 1 - tcer_pkg::RATIO_W){1'b0}}, ratio_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               node_in = req_data.node;
               last_in = req_data.tour_end;
               if (req_data.func == tcer_pkg::FUNC_FORGET) begin
                  have_base_in = 1'b0;
               end else if (at_start_ff) begin
                  // Drop the first node; the walk starts at the depot
                  at_start_in = 1'b0;
                  prior_in    = '0;
                  shared_in   = '0;
                  edges_in    = '0;
                  if (req_data.tour_end) begin
                     state_in = S_END;
                  end
               end else begin
                  // Baseline row of the prior node is being read
                  state_in = S_RD_P;
               end
            end
         end
         S_RD_P: begin
            hit_in   = have_base_ff && live_ff[bank_sel_ff][prior_ff] && rd_data[node_ff];
            rd_addr  = {wbank, prior_ff};
            state_in = S_WR_P;
         end
         S_WR_P: begin
            // Set bit (prior, node) and fetch the row of node
            wr_en   = 1'b1;
            wr_addr = {wbank, prior_ff};
            wr_data = (live_ff[wbank][prior_ff] ? rd_data : '0)
                      | (tcer_pkg::row_type'(1) << node_ff);
            row_in  = wr_data;
            live_in[wbank][prior_ff] = 1'b1;
            rd_addr  = {wbank, node_ff};
            state_in = S_WR_N;
         end
         S_WR_N: begin
            // Set bit (node, prior); forward the row just written on a self loop
            wr_en   = 1'b1;
            wr_addr = {wbank, node_ff};
            if (node_ff == prior_ff) begin
               wr_data = row_ff;
            end else begin
               wr_data = (live_ff[wbank][node_ff] ? rd_data : '0)
                         | (tcer_pkg::row_type'(1) << prior_ff);
            end
            live_in[wbank][node_ff] = 1'b1;
            if (edges_ff < tcer_pkg::MAX_TOUR_EDGES) begin
               shared_in = shared_ff + tcer_pkg::EDGE_W'(hit_ff);
               edges_in  = edges_ff + 1'b1;
            end
            prior_in = node_ff;
            state_in = last_ff ? S_END : S_IDLE;
         end
         S_END: begin
            if (have_base_ff && (edges_ff != '0)) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               ratio_in = '0;
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (div_done) begin
               ratio_in = div_quot;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Report once the output register is free, then swap the halves
            if (!rsp_valid_ff || rsp_ready) begin
               if (have_base_ff && !mism) begin
                  if (compared_ff != '1) begin
                     compared_in = compared_ff + 1'b1;
                  end
                  if (ident && (ident_cnt_ff != '1)) begin
                     ident_cnt_in = ident_cnt_ff + 1'b1;
                  end
                  ratio_acc_in = acc_sum[tcer_pkg::SUM_W] ? '1
                                 : acc_sum[tcer_pkg::SUM_W-1:0];
               end
               rsp_data_in.ratio_q16       = ratio_ff;
               rsp_data_in.common_edges    = have_base_ff ? shared_ff : '0;
               rsp_data_in.total_edges     = edges_ff;
               rsp_data_in.baseline_only   = !have_base_ff;
               rsp_data_in.identical       = have_base_ff && ident;
               rsp_data_in.length_mismatch = have_base_ff && mism;
               rsp_data_in.tours_compared  = compared_in;
               rsp_data_in.identical_tours = ident_cnt_in;
               rsp_data_in.ratio_total     = ratio_acc_in;
               rsp_valid_in = 1'b1;
               have_base_in = 1'b1;
               base_len_in  = edges_ff;
               bank_sel_in  = wbank;
               live_in[bank_sel_ff] = '0;
               at_start_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, counters and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         bank_sel_ff  <= 1'b0;
         have_base_ff <= 1'b0;
         at_start_ff  <= 1'b1;
         prior_ff     <= '0;
         shared_ff    <= '0;
         edges_ff     <= '0;
         base_len_ff  <= '0;
         compared_ff  <= '0;
         ident_cnt_ff <= '0;
         ratio_acc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         bank_sel_ff  <= bank_sel_in;
         have_base_ff <= have_base_in;
         at_start_ff  <= at_start_in;
         prior_ff     <= prior_in;
         shared_ff    <= shared_in;
         edges_ff     <= edges_in;
         base_len_ff  <= base_len_in;
         compared_ff  <= compared_in;
         ident_cnt_ff <= ident_cnt_in;
         ratio_acc_ff <= ratio_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff     <= node_in;
      last_ff     <= last_in;
      hit_ff      <= hit_in;
      row_ff      <= row_in;
      ratio_ff    <= ratio_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/tcer_checker.sv @@
// Port checker for the tour common-edge ratio core and its bind.
`default_nettype none

`include "tour_common_edge_ratio_core_assert.svh"

module tcer_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire tcer_pkg::rsp_type rsp_data
);

   // Hold a stalled result
   `TCER_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))

   // Keep the ratio within one
   `TCER_ASSERT_IMPLY(a_ratio_range, clock, reset, rsp_valid,
      rsp_data.ratio_q16 <= 17'd65536)

   // Count no more shared edges than edges
   `TCER_ASSERT_IMPLY(a_common_le_total, clock, reset, rsp_valid,
      rsp_data.common_edges <= rsp_data.total_edges)

   // Report no ratio, shared edges or flags for a baseline tour
   `TCER_ASSERT_IMPLY(a_baseline_quiet, clock, reset, rsp_valid && rsp_data.baseline_only,
      (rsp_data.ratio_q16 == '0) && (rsp_data.common_edges == '0)
      && !rsp_data.identical && !rsp_data.length_mismatch)

   // Give a full ratio for an identical tour
   `TCER_ASSERT_IMPLY(a_identical_full, clock, reset, rsp_valid && rsp_data.identical,
      (rsp_data.ratio_q16 == 17'd65536) && (rsp_data.common_edges == rsp_data.total_edges))

endmodule

bind tour_common_edge_ratio_core tcer_checker u_checker (.*);

`default_nettype wire

@@ tb/tcer_checker.sv @@
// Checker for the tour common-edge ratio core: predicts tour results and compares transfers.
module tcer_scoreboard
   import tcer_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           failures,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Edge maps of the baseline tour and of the tour being walked
   row_type baseline_rows [MAX_NODES];
   row_type walk_rows [MAX_NODES];

   bit                have_base;
   bit                tour_fresh;
   logic [NODE_W-1:0] from_node;
   int unsigned       shared_n;
   int unsigned       edges_n;
   int unsigned       base_len;
   int unsigned       compared_n;
   int unsigned       identical_n;
   longint unsigned   ratio_sum;

   rsp_type tour_results [$];
   int      shown;

   initial begin
      failures = 0;
      pending  = 0;
      shown    = 0;
   end

   // Fold one accepted transfer into the predicted state; queue a result at tour end
   task automatic fold_item(input req_type it);
      rsp_type     r;
      int unsigned q;
      r = '0;
      q = 0;
      if (it.func == FUNC_FORGET) begin
         have_base = 1'b0;
         return;
      end
      if (tour_fresh) begin
         // drop the first node, start the walk at the depot
         tour_fresh = 1'b0;
         from_node  = '0;
         shared_n   = 0;
         edges_n    = 0;
      end else begin
         // count only up to the saturation point, but always record the edge
         if (edges_n < MAX_TOUR_EDGES) begin
            if (have_base && baseline_rows[from_node][it.node]) shared_n++;
            edges_n++;
         end
         walk_rows[from_node][it.node] = 1'b1;
         walk_rows[it.node][from_node] = 1'b1;
         from_node = it.node;
      end
      if (!it.tour_end) return;

      r.total_edges = EDGE_W'(edges_n);
      if (!have_base) begin
         r.baseline_only = 1'b1;
      end else begin
         r.common_edges = EDGE_W'(shared_n);
         if (edges_n != 0) q = (shared_n << FRAC_W) / edges_n;
         r.ratio_q16       = RATIO_W'(q);
         r.identical       = (edges_n != 0) && (shared_n == edges_n);
         r.length_mismatch = (edges_n != base_len);
         // leave the tallies alone on a length mismatch
         if (!r.length_mismatch) begin
            if (compared_n < 16'hFFFF) compared_n++;
            if (r.identical && identical_n < 16'hFFFF) identical_n++;
            ratio_sum = ratio_sum + q;
            if (ratio_sum > 64'hFFFF_FFFF) ratio_sum = 64'hFFFF_FFFF;
         end
      end
      r.tours_compared  = TALLY_W'(compared_n);
      r.identical_tours = TALLY_W'(identical_n);
      r.ratio_total     = SUM_W'(ratio_sum);
      tour_results.insert(tour_results.size(), r);

      // promote the walked tour to baseline and start a clean map
      have_base     = 1'b1;
      base_len      = edges_n;
      baseline_rows = walk_rows;
      foreach (walk_rows[i]) walk_rows[i] = '0;
      tour_fresh    = 1'b1;
   endtask

   // Compare result transfers first, then absorb the request transfer of this edge
   always @(posedge clock) begin
      rsp_type want;
      string   notes;
      if (reset) begin
         foreach (baseline_rows[i]) begin
            baseline_rows[i] = '0;
            walk_rows[i]     = '0;
         end
         have_base   = 1'b0;
         tour_fresh  = 1'b1;
         from_node   = '0;
         shared_n    = 0;
         edges_n     = 0;
         base_len    = 0;
         compared_n  = 0;
         identical_n = 0;
         ratio_sum   = 0;
         tour_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tour_results.size() == 0) begin
               failures++;
               if (shown < 10) begin
                  shown++;
                  $display("%0t: result transfer with none expected: %h", $time, rsp_data);
               end
            end else begin
               want  = tour_results.pop_front();
               notes = "";
               if (rsp_data.ratio_q16 !== want.ratio_q16)
                  notes = {notes, $sformatf(" ratio_q16 exp %0d got %0d",
                                            want.ratio_q16, rsp_data.ratio_q16)};
               if (rsp_data.common_edges !== want.common_edges)
                  notes = {notes, $sformatf(" common_edges exp %0d got %0d",
                                            want.common_edges, rsp_data.common_edges)};
               if (rsp_data.total_edges !== want.total_edges)
                  notes = {notes, $sformatf(" total_edges exp %0d got %0d",
                                            want.total_edges, rsp_data.total_edges)};
               if (rsp_data.baseline_only !== want.baseline_only)
                  notes = {notes, $sformatf(" baseline_only exp %b got %b",
                                            want.baseline_only, rsp_data.baseline_only)};
               if (rsp_data.identical !== want.identical)
                  notes = {notes, $sformatf(" identical exp %b got %b",
                                            want.identical, rsp_data.identical)};
               if (rsp_data.length_mismatch !== want.length_mismatch)
                  notes = {notes, $sformatf(" length_mismatch exp %b got %b",
                                            want.length_mismatch, rsp_data.length_mismatch)};
               if (rsp_data.tours_compared !== want.tours_compared)
                  notes = {notes, $sformatf(" tours_compared exp %0d got %0d",
                                            want.tours_compared, rsp_data.tours_compared)};
               if (rsp_data.identical_tours !== want.identical_tours)
                  notes = {notes, $sformatf(" identical_tours exp %0d got %0d",
                                            want.identical_tours, rsp_data.identical_tours)};
               if (rsp_data.ratio_total !== want.ratio_total)
                  notes = {notes, $sformatf(" ratio_total exp %0d got %0d",
                                            want.ratio_total, rsp_data.ratio_total)};
               if (notes != "") begin
                  failures++;
                  if (shown < 10) begin
                     shown++;
                     $display("%0t: result mismatch:%s", $time, notes);
                  end
               end
            end
         end
         if (req_valid && req_ready) fold_item(req_data);
      end
      pending = tour_results.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the tour common-edge ratio testbench: clock, reset, tour stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcer_pkg::*;

   localparam int ITEM_TARGET = 1700;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_START  = 3000;
   localparam int HOLD_CYCLES = 2500;
   localparam int SETTLE      = 50;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int failures;
   int pending;
   int items_sent;
   int burst_left;
   int cycle_count;

   // Node lists of the tour being sent and of the one before; entry 0 is the dropped node
   logic [NODE_W-1:0] route [$];
   logic [NODE_W-1:0] last_route [$];

   tour_common_edge_ratio_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   tcer_scoreboard checker_inst (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one transfer after a random gap and hold it until accepted
   task automatic send_item(input req_type it);
      int gap;
      int pick;
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 45) gap = 0;
         else if (pick < 85) gap = $urandom_range(1, 3);
         else if (pick < 96) gap = $urandom_range(4, 10);
         else gap = $urandom_range(20, 50);
         if ($urandom_range(0, 99) == 0) burst_left = $urandom_range(30, 120);
      end
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_node(input logic [NODE_W-1:0] n, input logic last);
      req_type it;
      it.func     = FUNC_NODE;
      it.node     = n;
      it.tour_end = last;
      send_item(it);
   endtask

   // Forget carries random node and end bits, which the block must ignore
   task automatic send_forget();
      req_type it;
      it.func     = FUNC_FORGET;
      it.node     = NODE_W'($urandom);
      it.tour_end = 1'($urandom);
      send_item(it);
   endtask

   // Send the current route as one tour, optionally with forgets slipped in
   task automatic send_tour(input bit noisy);
      for (int i = 0; i < route.size(); i++) begin
         if (noisy && $urandom_range(0, 49) == 0) send_forget();
         send_node(route[i], i == route.size() - 1);
      end
      last_route = route;
   endtask

   function automatic void fresh_route(input int len, input int span);
      route.delete();
      repeat (len) route.insert(route.size(), NODE_W'($urandom_range(0, span)));
   endfunction

   // Receiver: random stalls, runs without stalls, and one long hold-off
   initial begin : drain
      int  run;
      int  r;
      int  cycles_done;
      bit  held;
      logic level;
      rsp_ready   = 1'b0;
      cycles_done = 0;
      held        = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (!held && cycles_done >= HOLD_START) begin
            held = 1'b1;
            @(negedge clock) rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            cycles_done += HOLD_CYCLES;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               level = 1'b1;
               run   = $urandom_range(50, 200);
            end else if (r < 55) begin
               level = 1'b1;
               run   = $urandom_range(1, 8);
            end else if (r < 93) begin
               level = 1'b0;
               run   = $urandom_range(1, 3);
            end else begin
               level = 1'b0;
               run   = $urandom_range(15, 60);
            end
            @(negedge clock) rsp_ready <= level;
            repeat (run - 1) @(negedge clock);
            cycles_done += run;
         end
      end
   end

   // Abort a hung run
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL tour_common_edge_ratio_core");
      $finish;
   end

   // Stimulus and verdict
   initial begin : stimulus
      int pick;
      int tour_index;
      int tmp_i;
      int tmp_j;
      logic [NODE_W-1:0] swap;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      items_sent = 0;
      burst_left = 0;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // empty tour as first baseline, then an empty tour compared against it
      route = '{6'd63};
      send_tour(1'b0);
      route = '{6'd0};
      send_tour(1'b0);
      // back-and-forth tour against the empty baseline: length mismatch
      route = '{6'd5, 6'd63, 6'd0, 6'd63};
      send_tour(1'b0);
      // same tour again: identical, full ratio
      send_tour(1'b0);
      // self-loop at the depot plus two shared edges
      route = '{6'd63, 6'd0, 6'd63, 6'd0};
      send_tour(1'b0);
      // forget, then a tour that only becomes the baseline
      send_forget();
      route = '{6'd1, 6'd2, 6'd3};
      send_tour(1'b0);
      // forget in the middle of a tour
      send_node(6'd42, 1'b0);
      send_node(6'd2, 1'b0);
      send_forget();
      send_node(6'd3, 1'b1);
      last_route = '{6'd42, 6'd2, 6'd3};
      // alternating bit patterns
      route = '{6'd21, 6'd42, 6'd21, 6'd42};
      send_tour(1'b0);

      // Random tours: mostly variations of the previous tour
      tour_index = 0;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (last_route.size() > 60 && tour_index != 7) pick = 99;
         if (tour_index == 6) begin
            // long tour: edge counts saturate
            fresh_route($urandom_range(257, 270), 63);
         end else if (pick < 6) begin
            send_forget();
            continue;
         end else if (pick < 30 || tour_index == 7) begin
            route    = last_route;
            route[0] = NODE_W'($urandom);
         end else if (pick < 48) begin
            route = last_route;
            repeat ($urandom_range(1, 3))
               route[$urandom_range(0, route.size() - 1)] = NODE_W'($urandom_range(0, 7));
         end else if (pick < 58) begin
            // reverse the walk after the dropped node
            route = last_route;
            tmp_i = 1;
            tmp_j = route.size() - 1;
            while (tmp_i < tmp_j) begin
               swap         = route[tmp_i];
               route[tmp_i] = route[tmp_j];
               route[tmp_j] = swap;
               tmp_i++;
               tmp_j--;
            end
         end else if (pick < 66) begin
            // grow or shrink the previous tour by one node
            route = last_route;
            if (route.size() > 1 && $urandom_range(0, 1) == 1) void'(route.pop_back());
            else route.insert(route.size(), NODE_W'($urandom_range(0, 7)));
         end else begin
            fresh_route(($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                     : $urandom_range(13, 60),
                        ($urandom_range(0, 1) == 1) ? 7 : 63);
         end
         send_tour(1'b1);
         tour_index++;
      end
      @(negedge clock) req_valid <= 1'b0;

      // Drain outstanding results, then watch for stray transfers
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (failures == 0 && pending == 0) $display("PASS tour_common_edge_ratio_core");
      else $display("FAIL tour_common_edge_ratio_core");
      $finish;
   end

endmodule
